### rtl/core/relay_cycle_sequencer_core_assert.svh
// Assertion helpers for the relay cycle sequencer, sampled on clk, off during rst.
`ifndef RELAY_CYCLE_SEQUENCER_CORE_ASSERT_SVH
`define RELAY_CYCLE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rcs_pkg.sv
package rcs_pkg;

  typedef enum logic [1:0] {
    MODE_BLOCKING = 2'd0,
    MODE_SYNC     = 2'd1,
    MODE_ASYNC    = 2'd2,
    MODE_INDEP    = 2'd3
  } rcs_mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_R1_ON = 3'd1,
    PH_D1    = 3'd2,
    PH_R2_ON = 3'd3,
    PH_D2    = 3'd4,
    PH_FIN   = 3'd5
  } rcs_phase_t;

  // Register indexes on the config port
  localparam logic [2:0] REG_OP_MODE       = 3'd0;
  localparam logic [2:0] REG_GROUP_B       = 3'd1;
  localparam logic [2:0] REG_FIRST_ON_MS   = 3'd2;
  localparam logic [2:0] REG_FIRST_OFF_MS  = 3'd3;
  localparam logic [2:0] REG_SECOND_ON_MS  = 3'd4;
  localparam logic [2:0] REG_SECOND_OFF_MS = 3'd5;
  localparam logic [2:0] REG_CYCLE_LIMIT   = 3'd6;
  localparam logic [2:0] REG_ENDLESS       = 3'd7;

  localparam logic [23:0] TIME_RESET  = 24'd1000;
  localparam logic [15:0] LIMIT_RESET = 16'd1;

  typedef struct packed {
    rcs_mode_t   op_mode;
    logic        group_b;
    logic [23:0] first_on_ms;
    logic [23:0] first_off_ms;
    logic [23:0] second_on_ms;
    logic [23:0] second_off_ms;
    logic [15:0] cycle_limit;
    logic        endless;
  } rcs_cfg_t;

  typedef struct packed {
    logic start_one;
    logic start_two;
    logic stop_button;
  } rcs_btn_t;

  typedef struct packed {
    rcs_phase_t       phase;
    logic             seq_active;
    logic [23:0]      seq_timer;
    logic [15:0]      cycle_count;
    logic [31:0]      run_timer;
    logic             run_going;
    logic             wait_flag;
    logic [1:0]       relay;
    logic [1:0]       lock;
    logic [1:0]       osc_active;
    logic [1:0]       osc_on;
    logic [1:0][23:0] osc_timer;
  } rcs_state_t;

  typedef struct packed {
    logic        relay_first;
    logic        relay_second;
    logic [3:0]  lamp_pattern;
    logic        mode_blocked;
    logic        working;
    logic        finished;
    logic        awaiting_user;
    logic [15:0] cycles_done;
    logic [31:0] run_elapsed_ms;
  } rcs_result_t;

endpackage

### rtl/core/rcs_step.sv
module rcs_step (
  input  rcs_pkg::rcs_cfg_t    cfg,
  input  rcs_pkg::rcs_state_t  st,
  input  rcs_pkg::rcs_btn_t    btn,
  output rcs_pkg::rcs_state_t  st_next,
  output rcs_pkg::rcs_result_t res
);
  import rcs_pkg::*;

  function automatic logic [23:0] inc24(input logic [23:0] t);
    return (t != 24'hFF_FFFF) ? t + 24'd1 : t;
  endfunction

  function automatic logic [3:0] mirror(input logic [1:0] r);
    return {1'b0, r[1], 1'b0, r[0]};
  endfunction

  rcs_state_t  nx;
  logic        any;
  logic        blocked;
  logic [1:0]  pre;
  logic [15:0] cc_inc;
  logic [3:0]  lamps;
  logic        working;
  logic        finished;
  logic [23:0] on_t;
  logic [23:0] off_t;

  always_comb begin
    nx       = st;
    any      = btn.start_one | btn.start_two | btn.stop_button;
    blocked  = cfg.group_b & ((cfg.op_mode == MODE_ASYNC) | (cfg.op_mode == MODE_INDEP));
    pre      = st.relay;
    cc_inc   = st.cycle_count;
    lamps    = 4'd0;
    working  = 1'b0;
    finished = 1'b0;
    on_t     = cfg.first_on_ms;
    off_t    = cfg.first_off_ms;

    // time base
    nx.seq_timer    = inc24(st.seq_timer);
    nx.osc_timer[0] = inc24(st.osc_timer[0]);
    nx.osc_timer[1] = inc24(st.osc_timer[1]);
    if (st.run_going && (st.run_timer != 32'hFFFF_FFFF)) begin
      nx.run_timer = st.run_timer + 32'd1;
    end

    if (blocked) begin
      nx.relay = 2'b00;
      lamps    = 4'hF;
    end else begin
      if (st.wait_flag && any) begin
        nx.cycle_count = 16'd0;
        nx.run_going   = 1'b0;
        nx.wait_flag   = 1'b0;
      end

      if ((cfg.op_mode == MODE_BLOCKING) || (cfg.op_mode == MODE_INDEP)) begin
        working = (st.relay != 2'b00);
      end

      case (cfg.op_mode)
        MODE_BLOCKING: begin
          if (!cfg.group_b) begin
            if (btn.start_one) nx.relay = 2'b01;
            if (btn.start_two) nx.relay = 2'b10;
            lamps = mirror(nx.relay);
          end else begin
            if (btn.stop_button) begin
              nx.relay = 2'b00;
              nx.lock  = 2'b00;
            end else begin
              if (!st.lock[0] && btn.start_one && (pre == 2'b00)) begin
                nx.relay[0] = 1'b1;
                nx.lock[0]  = 1'b1;
              end
              if (!st.lock[1] && btn.start_two && (pre == 2'b00)) begin
                nx.relay[1] = 1'b1;
                nx.lock[1]  = 1'b1;
              end
            end
            lamps = mirror(pre);
          end
        end
        MODE_SYNC: begin
          nx.osc_active = 2'b00;
          finished      = (st.phase == PH_FIN);
          working       = st.seq_active & ~finished;
          if (!st.seq_active) begin
            if (btn.start_one || btn.start_two) begin
              nx.seq_active  = 1'b1;
              nx.cycle_count = 16'd0;
              nx.run_timer   = 32'd0;
              nx.run_going   = 1'b1;
              nx.relay       = 2'b01;
              nx.phase       = PH_R1_ON;
              nx.seq_timer   = 24'd0;
              lamps          = 4'b0001;
            end
          end else begin
            unique case (st.phase)
              PH_R1_ON: begin
                if (nx.seq_timer >= cfg.first_on_ms) begin
                  nx.relay[0]  = 1'b0;
                  nx.phase     = PH_D1;
                  nx.seq_timer = 24'd0;
                end
              end
              PH_D1: begin
                if (nx.seq_timer >= cfg.first_off_ms) begin
                  nx.relay[1]  = 1'b1;
                  nx.phase     = PH_R2_ON;
                  nx.seq_timer = 24'd0;
                end
              end
              PH_R2_ON: begin
                if (nx.seq_timer >= cfg.second_on_ms) begin
                  nx.relay[1]  = 1'b0;
                  nx.phase     = PH_D2;
                  nx.seq_timer = 24'd0;
                end
              end
              PH_D2: begin
                if (nx.seq_timer >= cfg.second_off_ms) begin
                  cc_inc = (nx.cycle_count != 16'hFFFF) ? nx.cycle_count + 16'd1
                                                        : nx.cycle_count;
                  nx.cycle_count = cc_inc;
                  nx.seq_timer   = 24'd0;
                  if (!cfg.endless && (cc_inc >= cfg.cycle_limit)) begin
                    nx.phase     = PH_FIN;
                    nx.run_going = 1'b0;
                    nx.wait_flag = 1'b1;
                  end else begin
                    nx.relay[0] = 1'b1;
                    nx.phase    = PH_R1_ON;
                  end
                end
              end
              PH_FIN: begin
                nx.run_going = 1'b0;
                nx.wait_flag = 1'b1;
                if (any) begin
                  nx.seq_active = 1'b0;
                  nx.phase      = PH_IDLE;
                  nx.wait_flag  = 1'b0;
                  nx.run_timer  = 32'd0;
                end
              end
              default: begin
              end
            endcase
            case (nx.phase)
              PH_R1_ON: lamps = 4'b0001;
              PH_D1:    lamps = 4'b0010;
              PH_R2_ON: lamps = 4'b0100;
              PH_D2:    lamps = 4'b1000;
              default:  lamps = 4'b0000;
            endcase
          end
        end
        MODE_ASYNC: begin
          working = (st.osc_active != 2'b00);
          if (btn.stop_button) begin
            nx.osc_active = 2'b00;
            nx.relay      = 2'b00;
          end else begin
            if (btn.start_one) begin
              if (st.osc_active[0]) begin
                nx.osc_active[0] = 1'b0;
                nx.relay[0]      = 1'b0;
              end else begin
                nx.osc_active[0] = 1'b1;
                nx.osc_on[0]     = 1'b1;
                nx.osc_timer[0]  = 24'd0;
                nx.relay[0]      = 1'b1;
              end
            end
            if (btn.start_two) begin
              if (st.osc_active[1]) begin
                nx.osc_active[1] = 1'b0;
                nx.relay[1]      = 1'b0;
              end else begin
                nx.osc_active[1] = 1'b1;
                nx.osc_on[1]     = 1'b1;
                nx.osc_timer[1]  = 24'd0;
                nx.relay[1]      = 1'b1;
              end
            end
          end
          // two independent oscillators, one per relay
          for (int k = 0; k < 2; k++) begin
            on_t  = (k == 0) ? cfg.first_on_ms : cfg.second_on_ms;
            off_t = (k == 0) ? cfg.first_off_ms : cfg.second_off_ms;
            if (nx.osc_active[k]) begin
              if (nx.osc_on[k]) begin
                if (nx.osc_timer[k] >= on_t) begin
                  nx.relay[k]     = 1'b0;
                  nx.osc_on[k]    = 1'b0;
                  nx.osc_timer[k] = 24'd0;
                end
              end else begin
                if (nx.osc_timer[k] >= off_t) begin
                  nx.relay[k]     = 1'b1;
                  nx.osc_on[k]    = 1'b1;
                  nx.osc_timer[k] = 24'd0;
                end
              end
            end
          end
          lamps = mirror(nx.relay);
        end
        default: begin
          if (btn.start_one) nx.relay[0] = ~st.relay[0];
          if (btn.start_two) nx.relay[1] = ~st.relay[1];
          lamps = mirror(nx.relay);
        end
      endcase
    end

    st_next                = nx;
    res.relay_first        = nx.relay[0];
    res.relay_second       = nx.relay[1];
    res.lamp_pattern       = lamps;
    res.mode_blocked       = blocked;
    res.working            = working;
    res.finished           = finished;
    res.awaiting_user      = nx.wait_flag;
    res.cycles_done        = nx.cycle_count;
    res.run_elapsed_ms     = nx.run_timer;
  end

endmodule

### rtl/core/relay_cycle_sequencer_core.sv
// Relay cycle sequencer core.
// Input channel (in_valid / in_stall): one item per millisecond tick carrying
// the start_one, start_two and stop_button states for that tick. An item is
// taken on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in order: relay drives, lamp pattern, blocked / working / finished /
// awaiting status, completed cycles and elapsed run time.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; index 0..7 selects op_mode, group_b, the four phase times,
// cycle_limit and endless. Write only while no item is in flight.
// Result path: input register, then result register; the item moves on once
// the result register is free, which out_stall can delay.
// Throughput: one item per clock unless out_stall holds a result; the whole
// tick update is a single pass of compare/increment logic between them.
// Stall: while out_stall holds a result, one more item is taken into the
// input register; in_stall then rises until the result drains.
// Reset (rst, synchronous): relays off, sequencer idle, counters and timers
// zero, all config registers back to defaults (1000 ms times, limit 1).
module relay_cycle_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_one,
  input  logic        start_two,
  input  logic        stop_button,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        relay_first,
  output logic        relay_second,
  output logic [3:0]  lamp_pattern,
  output logic        mode_blocked,
  output logic        working,
  output logic        finished,
  output logic        awaiting_user,
  output logic [15:0] cycles_done,
  output logic [31:0] run_elapsed_ms,
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import rcs_pkg::*;

  rcs_cfg_t    cfg;
  rcs_state_t  state;
  rcs_state_t  state_next;
  rcs_btn_t    in_btn;
  rcs_result_t step_res;
  rcs_result_t out_res;
  logic        in_full;
  logic        out_free;
  logic        in_move;
  logic        in_take;

  // handshake
  assign out_free  = ~out_valid | ~out_stall;
  assign in_move   = in_full & out_free;
  assign in_stall  = in_full & ~out_free;
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // one tick of work
  rcs_step u_step (
    .cfg     (cfg),
    .st      (state),
    .btn     (in_btn),
    .st_next (state_next),
    .res     (step_res)
  );

  // control, state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      state     <= '{phase: PH_IDLE, default: '0};
      cfg       <= '{op_mode:       MODE_BLOCKING,
                     group_b:       1'b0,
                     first_on_ms:   TIME_RESET,
                     first_off_ms:  TIME_RESET,
                     second_on_ms:  TIME_RESET,
                     second_off_ms: TIME_RESET,
                     cycle_limit:   LIMIT_RESET,
                     endless:       1'b0};
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (in_move) begin
        in_full <= 1'b0;
      end

      if (in_move) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OP_MODE:       cfg.op_mode       <= rcs_mode_t'(cfg_data[1:0]);
          REG_GROUP_B:       cfg.group_b       <= cfg_data[0];
          REG_FIRST_ON_MS:   cfg.first_on_ms   <= cfg_data;
          REG_FIRST_OFF_MS:  cfg.first_off_ms  <= cfg_data;
          REG_SECOND_ON_MS:  cfg.second_on_ms  <= cfg_data;
          REG_SECOND_OFF_MS: cfg.second_off_ms <= cfg_data;
          REG_CYCLE_LIMIT:   cfg.cycle_limit   <= cfg_data[15:0];
          REG_ENDLESS:       cfg.endless       <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_btn <= '{start_one: start_one, start_two: start_two, stop_button: stop_button};
    end
    if (in_move) begin
      out_res <= step_res;
    end
  end

  assign relay_first    = out_res.relay_first;
  assign relay_second   = out_res.relay_second;
  assign lamp_pattern   = out_res.lamp_pattern;
  assign mode_blocked   = out_res.mode_blocked;
  assign working        = out_res.working;
  assign finished       = out_res.finished;
  assign awaiting_user  = out_res.awaiting_user;
  assign cycles_done    = out_res.cycles_done;
  assign run_elapsed_ms = out_res.run_elapsed_ms;

`include "relay_cycle_sequencer_core_assert.svh"

  `RCS_ASSERT_IMP(a_stall_only_full, in_stall, in_full, "input stalled while input register empty")
  `RCS_ASSERT_NXT(a_move_loads_out, in_move, out_valid, "item left input register but no result")
  `RCS_ASSERT_IMP(a_wait_not_running, state.wait_flag, !state.run_going, "waiting with run timer going")
  `RCS_ASSERT_IMP(a_blocked_all_off, out_valid && mode_blocked, !relay_first && !relay_second && (lamp_pattern == 4'hF), "blocked result with relay on")

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rcs_pkg::*;

  // Cycles with no handshake of any kind before the run is declared hung
  localparam int QUIET_LIMIT   = 5000;
  localparam int REPORT_MAX    = 10;
  // Quiet ticks of the endless sync run before endless is dropped
  localparam int ENDLESS_TICKS = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        start_one = 1'b0;
  logic        start_two = 1'b0;
  logic        stop_button = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        relay_first;
  logic        relay_second;
  logic [3:0]  lamp_pattern;
  logic        mode_blocked;
  logic        working;
  logic        finished;
  logic        awaiting_user;
  logic [15:0] cycles_done;
  logic [31:0] run_elapsed_ms;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_OP_MODE;
  logic [23:0] cfg_data = 24'd0;

  relay_cycle_sequencer_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .start_one      (start_one),
    .start_two      (start_two),
    .stop_button    (stop_button),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .relay_first    (relay_first),
    .relay_second   (relay_second),
    .lamp_pattern   (lamp_pattern),
    .mode_blocked   (mode_blocked),
    .working        (working),
    .finished       (finished),
    .awaiting_user  (awaiting_user),
    .cycles_done    (cycles_done),
    .run_elapsed_ms (run_elapsed_ms),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer mirror: register copies and tick state, starting at reset values
  // ---------------------------------------------------------------------------
  rcs_mode_t   mode_reg    = MODE_BLOCKING;
  logic        grp_b       = 1'b0;
  logic [23:0] t1_on       = TIME_RESET;
  logic [23:0] t1_off      = TIME_RESET;
  logic [23:0] t2_on       = TIME_RESET;
  logic [23:0] t2_off      = TIME_RESET;
  logic [15:0] cyc_limit   = LIMIT_RESET;
  logic        endless_on  = 1'b0;

  rcs_phase_t  ph          = PH_IDLE;
  logic        seq_on      = 1'b0;
  logic [23:0] seq_tmr     = 24'd0;
  logic [15:0] cyc_cnt     = 16'd0;
  logic [31:0] run_tmr     = 32'd0;
  logic        run_on      = 1'b0;
  logic        user_wait   = 1'b0;
  logic [1:0]  relays      = 2'b00;
  logic [1:0]  locks       = 2'b00;
  logic [1:0]  osc_en      = 2'b00;
  logic [1:0]  osc_hi      = 2'b00;
  logic [23:0] osc_tmr [2] = '{24'd0, 24'd0};

  rcs_result_t due_results [$];
  rcs_result_t seen_item;
  rcs_result_t want_item;
  int          fail_count     = 0;
  int          quiet_cycles   = 0;
  int          send_gap_pct   = 9;
  int          recv_stall_pct = 77;

  // One millisecond tick of the relay sequencer; returns the result it causes.
  function automatic rcs_result_t relay_tick(input logic s1, input logic s2, input logic sp);
    logic        any_btn;
    logic        blk;
    logic        busy;
    logic        done;
    logic [1:0]  starts;
    logic [1:0]  pre;
    logic [3:0]  lamps;
    logic [23:0] on_t;
    logic [23:0] off_t;
    int          k;
    rcs_result_t r;
    any_btn = s1 | s2 | sp;
    starts  = {s2, s1};
    blk     = grp_b && (mode_reg == MODE_ASYNC || mode_reg == MODE_INDEP);
    lamps   = 4'd0;
    busy    = 1'b0;
    done    = 1'b0;

    // time base advances before anything looks at it
    if (seq_tmr != 24'hFFFFFF) seq_tmr++;
    for (k = 0; k < 2; k++) if (osc_tmr[k] != 24'hFFFFFF) osc_tmr[k]++;
    if (run_on && run_tmr != 32'hFFFFFFFF) run_tmr++;

    if (blk) begin
      // forbidden mode for group B: relays dropped, every lamp lit
      relays = 2'b00;
      lamps  = 4'hF;
    end else begin
      if (user_wait && any_btn) begin
        cyc_cnt   = 16'd0;
        run_on    = 1'b0;
        user_wait = 1'b0;
      end
      if (mode_reg == MODE_BLOCKING || mode_reg == MODE_INDEP) busy = relays != 2'b00;

      case (mode_reg)
        MODE_BLOCKING: begin
          pre = relays;
          if (!grp_b) begin
            // interlock: later start wins, other relay drops
            if (s1) relays = 2'b01;
            if (s2) relays = 2'b10;
            lamps = {1'b0, relays[1], 1'b0, relays[0]};
          end else begin
            if (sp) begin
              relays = 2'b00;
              locks  = 2'b00;
            end else begin
              for (k = 0; k < 2; k++) begin
                if (!locks[k] && starts[k] && pre == 2'b00) begin
                  relays[k] = 1'b1;
                  locks[k]  = 1'b1;
                end
              end
            end
            lamps = {1'b0, pre[1], 1'b0, pre[0]};
          end
        end
        MODE_SYNC: begin
          osc_en = 2'b00;
          done   = (ph == PH_FIN);
          busy   = seq_on && !done;
          if (!seq_on) begin
            if (s1 || s2) begin
              seq_on  = 1'b1;
              cyc_cnt = 16'd0;
              run_tmr = 32'd0;
              run_on  = 1'b1;
              relays  = 2'b01;
              ph      = PH_R1_ON;
              seq_tmr = 24'd0;
              lamps   = 4'b0001;
            end
          end else begin
            case (ph)
              PH_R1_ON: if (seq_tmr >= t1_on) begin
                relays[0] = 1'b0;
                ph        = PH_D1;
                seq_tmr   = 24'd0;
              end
              PH_D1: if (seq_tmr >= t1_off) begin
                relays[1] = 1'b1;
                ph        = PH_R2_ON;
                seq_tmr   = 24'd0;
              end
              PH_R2_ON: if (seq_tmr >= t2_on) begin
                relays[1] = 1'b0;
                ph        = PH_D2;
                seq_tmr   = 24'd0;
              end
              PH_D2: if (seq_tmr >= t2_off) begin
                if (cyc_cnt != 16'hFFFF) cyc_cnt++;
                seq_tmr = 24'd0;
                if (!endless_on && cyc_cnt >= cyc_limit) begin
                  ph        = PH_FIN;
                  run_on    = 1'b0;
                  user_wait = 1'b1;
                end else begin
                  relays[0] = 1'b1;
                  ph        = PH_R1_ON;
                end
              end
              PH_FIN: begin
                run_on    = 1'b0;
                user_wait = 1'b1;
                if (any_btn) begin
                  seq_on    = 1'b0;
                  ph        = PH_IDLE;
                  user_wait = 1'b0;
                  run_tmr   = 32'd0;
                end
              end
              default: ;
            endcase
            // one-hot lamp per running phase
            if (ph >= PH_R1_ON && ph <= PH_D2) lamps = 4'b0001 << (ph - PH_R1_ON);
          end
        end
        MODE_ASYNC: begin
          busy = osc_en != 2'b00;
          if (sp) begin
            osc_en = 2'b00;
            relays = 2'b00;
          end else begin
            for (k = 0; k < 2; k++) begin
              if (starts[k]) begin
                if (osc_en[k]) begin
                  osc_en[k] = 1'b0;
                  relays[k] = 1'b0;
                end else begin
                  osc_en[k]  = 1'b1;
                  osc_hi[k]  = 1'b1;
                  osc_tmr[k] = 24'd0;
                  relays[k]  = 1'b1;
                end
              end
            end
          end
          // each oscillator flips once its current half-period has run out
          for (k = 0; k < 2; k++) begin
            on_t  = (k == 0) ? t1_on : t2_on;
            off_t = (k == 0) ? t1_off : t2_off;
            if (osc_en[k]) begin
              if (osc_hi[k]) begin
                if (osc_tmr[k] >= on_t) begin
                  relays[k]  = 1'b0;
                  osc_hi[k]  = 1'b0;
                  osc_tmr[k] = 24'd0;
                end
              end else if (osc_tmr[k] >= off_t) begin
                relays[k]  = 1'b1;
                osc_hi[k]  = 1'b1;
                osc_tmr[k] = 24'd0;
              end
            end
          end
          lamps = {1'b0, relays[1], 1'b0, relays[0]};
        end
        default: begin
          // independent: each start toggles its own relay
          relays = relays ^ starts;
          lamps  = {1'b0, relays[1], 1'b0, relays[0]};
        end
      endcase
    end

    r.relay_first    = relays[0];
    r.relay_second   = relays[1];
    r.lamp_pattern   = lamps;
    r.mode_blocked   = blk;
    r.working        = busy;
    r.finished       = done;
    r.awaiting_user  = user_wait;
    r.cycles_done    = cyc_cnt;
    r.run_elapsed_ms = run_tmr;
    return r;
  endfunction

  function automatic string show_result(input rcs_result_t r);
    return $sformatf("r1=%0d r2=%0d lamp=%h blk=%0d wrk=%0d fin=%0d wait=%0d cyc=%0d ms=%0d",
                     r.relay_first, r.relay_second, r.lamp_pattern, r.mode_blocked,
                     r.working, r.finished, r.awaiting_user, r.cycles_done,
                     r.run_elapsed_ms);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One tick item. in_valid is only dropped inside a gap, so back-to-back
  // items keep it high without a same-step low/high pair.
  task automatic send_tick(input logic s1, input logic s2, input logic sp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_one   <= s1;
    start_two   <= s2;
    stop_button <= sp;
    do @(posedge clk); while (in_stall);
    due_results.push_back(relay_tick(s1, s2, sp));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OP_MODE:       mode_reg   = rcs_mode_t'(val[1:0]);
      REG_GROUP_B:       grp_b      = val[0];
      REG_FIRST_ON_MS:   t1_on      = val;
      REG_FIRST_OFF_MS:  t1_off     = val;
      REG_SECOND_ON_MS:  t2_on      = val;
      REG_SECOND_OFF_MS: t2_off     = val;
      REG_CYCLE_LIMIT:   cyc_limit  = val[15:0];
      REG_ENDLESS:       endless_on = val[0];
      default: ;
    endcase
    // gap cycle keeps consecutive writes from sharing a step
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: wait until no result is pending, then let the pipeline go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly short phase times so sequences turn over; now and then an extreme
  function automatic logic [23:0] pick_time();
    case ($urandom_range(9))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2:       return 24'd1;
      default: return 24'($urandom_range(12, 2));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_manual_blocking();
    // group A interlock, reset config
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    // group B latched locks: second start refused, stop clears, both at once
    settle();
    write_reg(REG_GROUP_B, 24'd1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_sync_single_cycle();
    settle();
    write_reg(REG_GROUP_B, 24'd0);
    write_reg(REG_OP_MODE, 24'(MODE_SYNC));
    write_reg(REG_FIRST_ON_MS, 24'd0);
    write_reg(REG_FIRST_OFF_MS, 24'd0);
    write_reg(REG_SECOND_ON_MS, 24'd0);
    write_reg(REG_SECOND_OFF_MS, 24'd0);
    write_reg(REG_CYCLE_LIMIT, 24'd1);
    write_reg(REG_ENDLESS, 24'd0);
    // start, walk all four phases, sit in finish, then release
    send_tick(1'b1, 1'b0, 1'b0);
    repeat (5) send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_async_and_toggle();
    settle();
    write_reg(REG_OP_MODE, 24'(MODE_ASYNC));
    write_reg(REG_FIRST_ON_MS, 24'd2);
    write_reg(REG_FIRST_OFF_MS, 24'd1);
    write_reg(REG_SECOND_ON_MS, 24'd0);
    write_reg(REG_SECOND_OFF_MS, 24'd3);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    settle();
    write_reg(REG_OP_MODE, 24'(MODE_INDEP));
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_group_b_blocked();
    // group B refuses independent and async modes
    settle();
    write_reg(REG_GROUP_B, 24'd1);
    send_tick(1'b1, 1'b0, 1'b0);
    settle();
    write_reg(REG_OP_MODE, 24'(MODE_ASYNC));
    send_tick(1'b0, 1'b1, 1'b0);
  endtask

  // Segments of random config, each followed by mostly quiet ticks with
  // sparse presses so timed phases get to run between button events.
  task automatic test_random_ticks(input int n_items, input int gap_pct, input int stall_pct);
    int         sent;
    int         seg_len;
    logic       b1;
    logic       b2;
    logic       b3;
    rcs_mode_t  m;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      settle();
      m = ($urandom_range(9) < 4) ? MODE_SYNC : rcs_mode_t'($urandom_range(3));
      // upper data bits are don't-care for the narrow registers
      write_reg(REG_OP_MODE, {22'($urandom()), 2'(m)});
      write_reg(REG_GROUP_B, {23'($urandom()), 1'($urandom_range(2) == 0)});
      if ($urandom_range(1)) write_reg(REG_FIRST_ON_MS, pick_time());
      if ($urandom_range(1)) write_reg(REG_FIRST_OFF_MS, pick_time());
      if ($urandom_range(1)) write_reg(REG_SECOND_ON_MS, pick_time());
      if ($urandom_range(1)) write_reg(REG_SECOND_OFF_MS, pick_time());
      if ($urandom_range(1)) begin
        case ($urandom_range(5))
          0:       write_reg(REG_CYCLE_LIMIT, {8'($urandom()), 16'd0});
          1:       write_reg(REG_CYCLE_LIMIT, {8'($urandom()), 16'hFFFF});
          default: write_reg(REG_CYCLE_LIMIT, {8'($urandom()), 16'($urandom_range(4, 1))});
        endcase
      end
      if ($urandom_range(3) == 0)
        write_reg(REG_ENDLESS, {23'($urandom()), 1'($urandom_range(2) == 0)});
      seg_len = $urandom_range(60, 20);
      repeat (seg_len) begin
        b1 = ($urandom_range(11) == 0);
        b2 = ($urandom_range(11) == 0);
        b3 = ($urandom_range(11) == 0);
        send_tick(b1, b2, b3);
      end
      sent += seg_len;
    end
  endtask

  // Endless run at zero phase times keeps cycling past the limit; dropping
  // endless then finishes at the next cycle end.
  task automatic test_endless_then_finish();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    settle();
    write_reg(REG_OP_MODE, 24'(MODE_SYNC));
    write_reg(REG_GROUP_B, 24'd0);
    write_reg(REG_FIRST_ON_MS, 24'd0);
    write_reg(REG_FIRST_OFF_MS, 24'd0);
    write_reg(REG_SECOND_ON_MS, 24'd0);
    write_reg(REG_SECOND_OFF_MS, 24'd0);
    write_reg(REG_CYCLE_LIMIT, 24'd0);
    write_reg(REG_ENDLESS, 24'd0);
    // bring any leftover sequence to finish and release it
    while (seq_on) send_tick(1'b0, 1'b0, 1'b1);
    settle();
    write_reg(REG_CYCLE_LIMIT, 24'd2);
    write_reg(REG_ENDLESS, 24'd1);
    send_tick(1'b1, 1'b0, 1'b0);
    repeat (ENDLESS_TICKS) send_tick(1'b0, 1'b0, 1'b0);
    settle();
    write_reg(REG_ENDLESS, 24'd0);
    repeat (8) send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    repeat (2) send_tick(1'b0, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall, result checker, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else     out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_item.relay_first    = relay_first;
      seen_item.relay_second   = relay_second;
      seen_item.lamp_pattern   = lamp_pattern;
      seen_item.mode_blocked   = mode_blocked;
      seen_item.working        = working;
      seen_item.finished       = finished;
      seen_item.awaiting_user  = awaiting_user;
      seen_item.cycles_done    = cycles_done;
      seen_item.run_elapsed_ms = run_elapsed_ms;
      if (due_results.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("%0t: result item with nothing pending: %s", $time, show_result(seen_item));
        fail_count++;
      end else begin
        want_item = due_results.pop_front();
        if (seen_item !== want_item) begin
          if (fail_count < REPORT_MAX) begin
            $display("%0t: result item differs", $time);
            $display("  exp %s", show_result(want_item));
            $display("  got %s", show_result(seen_item));
          end
          fail_count++;
        end
      end
    end
  end

  // Hang detector: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part and first random third: sender rarely idles, receiver mostly stalls
    test_manual_blocking();
    test_sync_single_cycle();
    test_async_and_toggle();
    test_group_b_blocked();
    test_random_ticks(200, 9, 77);
    // swap: bursty sender, receiver rarely stalls
    test_random_ticks(200, 77, 9);
    // full rate both sides
    test_random_ticks(200, 0, 0);
    test_endless_then_finish();

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
